### src/rss_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the running stream statistics block.
package rss_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;

  // Accumulator widths: exact for any sample pattern up to a full count.
  localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1 + COUNT_BITS;

  // Serial multiplier: multiplicand, multiplier and product widths.
  localparam int MA_W   = SQ_W;
  localparam int MB_W   = SUM_W;
  localparam int PROD_W = MA_W + MB_W;

  // count*sumsq - sum*sum, and the count*count divisor.
  localparam int DIFF_W = COUNT_BITS + SQ_W;
  localparam int DEN_W  = 2 * COUNT_BITS;

  // Square root: radicand (even width), root and partial remainder.
  localparam int ROOT_IN_W  = 2 * SAMPLE_BITS + 2;
  localparam int ROOT_W     = ROOT_IN_W / 2;
  localparam int ROOT_REM_W = SAMPLE_BITS + 4;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample;
  } rss_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] min_value;
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic signed [SAMPLE_BITS-1:0] mean_value;
    logic        [SAMPLE_BITS-1:0] std_dev;
    logic        [COUNT_BITS-1:0]  sample_total;
    logic                          empty_res;
    logic                          saturated;
  } rss_out_t;

  typedef struct packed {
    logic            start;
    logic            short_op;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } rss_mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } rss_mul_res_t;

  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] num;
    logic [DEN_W-1:0]  den;
  } rss_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [ROOT_IN_W-1:0] quot;
  } rss_div_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MEAN,
    ST_PROD,
    ST_SQSUM,
    ST_NSQ,
    ST_VAR,
    ST_ROOT,
    ST_EMIT
  } rss_state_e;

endpackage

### src/rss_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module rss_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rss_pkg::rss_mul_req_t req_i,
  output rss_pkg::rss_mul_res_t res_o
);

  localparam int MaW    = rss_pkg::MA_W;
  localparam int MbW    = rss_pkg::MB_W;
  localparam int ProdW  = rss_pkg::PROD_W;
  localparam int ShortW = rss_pkg::SAMPLE_BITS;
  localparam int CntW   = $clog2(MbW + 1);

  logic [MaW-1:0]        a_q;
  logic [MaW-1:0]        hi_q, hi_d;
  logic [MbW-1:0]        lo_q, lo_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  short_q;
  logic [MaW:0]          acc;
  logic [MaW+ShortW-1:0] short_prod;

  always_comb begin
    acc    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      hi_d   = '0;
      lo_d   = req_i.b;
      cnt_d  = req_i.short_op ? CntW'(ShortW) : CntW'(MbW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // add on the low multiplier bit, then shift the product pair right
      hi_d  = acc[MaW:1];
      lo_d  = {acc[0], lo_q[MbW-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (req_i.start) begin
      a_q     <= req_i.a;
      short_q <= req_i.short_op;
    end
  end

  // a short run stops early, so its product sits higher in the pair
  assign short_prod = {hi_q, lo_q[MbW-1 -: ShortW]};

  assign res_o.done = done_q;
  assign res_o.prod = short_q ? ProdW'(short_prod) : {hi_q, lo_q};

endmodule

### src/rss_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
module rss_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rss_pkg::rss_div_req_t req_i,
  output rss_pkg::rss_div_res_t res_o
);

  localparam int NumW = rss_pkg::DIFF_W;
  localparam int DenW = rss_pkg::DEN_W;
  localparam int QW   = rss_pkg::ROOT_IN_W;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [QW-1:0]   quot_q, quot_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   rem_sh;
  logic [DenW:0]   rem_sub;
  logic            fits;

  always_comb begin
    rem_sh  = {rem_q, num_q[NumW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = rem_sh >= {1'b0, den_q};
    num_d   = num_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.num;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits back in DenW bits
      num_d  = {num_q[NumW-2:0], 1'b0};
      rem_d  = fits ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
      quot_d = {quot_q[QW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (req_i.start) begin
      den_q <= req_i.den;
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;

endmodule

### src/running_stream_statistics.sv
`timescale 1ns / 1ps
// Top level of the running stream statistics block: min, max, mean and deviation.
//
//   channel | direction | handshake                     | payload
//   --------+-----------+-------------------------------+--------------------------
//   in      | input     | in_valid_i / in_stall_o       | rss_in_t  (kind, sample)
//   out     | output    | out_valid_o / out_stall_i     | rss_out_t (report result)
//
// A sample transaction occupies the block until its square is done:
// its square runs one bit per cycle through the shared serial multiplier.
// A report transaction runs a serial divide for the mean, three serial products, a serial
// divide for the variance and a two-bit-per-step square root, then loads the result once
// the output register is free.
// A sample dropped at full count leaves the block idle; a report with no samples goes straight to loading the result.
// Reset clears all accumulators and flags at once; there is no clearing pass.
// A stalled result waits in the output register while sample transactions keep flowing;
// only a second report waits until the first one has been taken.
module running_stream_statistics (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rss_pkg::rss_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rss_pkg::rss_out_t out_item_o
);

  localparam int SampleBits = rss_pkg::SAMPLE_BITS;
  localparam int CountBits  = rss_pkg::COUNT_BITS;
  localparam int SumW       = rss_pkg::SUM_W;
  localparam int SqW        = rss_pkg::SQ_W;
  localparam int MaW        = rss_pkg::MA_W;
  localparam int MbW        = rss_pkg::MB_W;
  localparam int DiffW      = rss_pkg::DIFF_W;
  localparam int DenW       = rss_pkg::DEN_W;
  localparam int RootInW    = rss_pkg::ROOT_IN_W;
  localparam int RootW      = rss_pkg::ROOT_W;
  localparam int RemW       = rss_pkg::ROOT_REM_W;
  localparam int RootSteps  = RootInW / 2;
  localparam int RtCntW     = $clog2(RootSteps + 1);

  rss_pkg::rss_state_e state_q, state_d;

  // running statistics
  logic signed [SampleBits-1:0] min_q, max_q;
  logic signed [SumW-1:0]       sum_q;
  logic [SqW-1:0]               sumsq_q;
  logic [CountBits-1:0]         cnt_q;
  logic                         dropped_q;

  // report working registers
  logic [SumW-1:0]       amag_q;
  logic                  neg_q;
  logic [DiffW-1:0]      diff_q;
  logic [SampleBits-1:0] mean_q;
  logic [RootInW-1:0]    rt_val_q;
  logic [RemW-1:0]       rt_rem_q;
  logic [RootW-1:0]      rt_root_q;
  logic [RtCntW-1:0]     rt_cnt_q;

  logic              out_valid_q;
  rss_pkg::rss_out_t out_q;

  logic                         accept;
  logic                         take_sample;
  logic                         take_report;
  logic                         cnt_full;
  logic                         cnt_zero;
  logic                         out_free;
  logic signed [SampleBits-1:0] sample_s;
  logic [SampleBits-1:0]        sample_mag;
  logic [SumW-1:0]              sum_mag;
  logic [SampleBits-1:0]        quot_lo;
  logic [1:0]                   rt_pair;
  logic [RemW+1:0]              rt_shift;
  logic [RemW+1:0]              rt_trial;
  logic [RemW+1:0]              rt_sub;
  logic                         rt_fits;

  rss_pkg::rss_mul_req_t mul_req;
  rss_pkg::rss_mul_res_t mul_res;
  rss_pkg::rss_div_req_t div_req;
  rss_pkg::rss_div_res_t div_res;

  rss_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .res_o  (mul_res)
  );

  rss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // Take a new transaction only while idle; the output register decouples the far side.
  assign in_stall_o  = (state_q != rss_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign take_sample = accept && (in_item_i.kind == rss_pkg::KIND_SAMPLE);
  assign take_report = accept && (in_item_i.kind == rss_pkg::KIND_REPORT);
  assign cnt_full    = &cnt_q;
  assign cnt_zero    = (cnt_q == '0);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign sample_s   = in_item_i.sample;
  assign sample_mag = sample_s[SampleBits-1] ? (~sample_s) + 1'b1 : sample_s;
  assign sum_mag    = sum_q[SumW-1] ? (~sum_q) + 1'b1 : sum_q;
  assign quot_lo    = div_res.quot[SampleBits-1:0];

  // One square-root step: bring down two radicand bits, try root*4 + 1.
  assign rt_pair  = rt_val_q[RootInW-1 -: 2];
  assign rt_shift = {rt_rem_q, rt_pair};
  assign rt_trial = (RemW + 2)'({rt_root_q, 2'b01});
  assign rt_sub   = rt_shift - rt_trial;
  assign rt_fits  = rt_shift >= rt_trial;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rss_pkg::ST_IDLE: begin
        if (take_sample && !cnt_full) begin
          state_d = rss_pkg::ST_SQUARE;
        end else if (take_report) begin
          state_d = cnt_zero ? rss_pkg::ST_EMIT : rss_pkg::ST_MEAN;
        end
      end
      rss_pkg::ST_SQUARE: begin
        if (mul_res.done) begin
          state_d = rss_pkg::ST_IDLE;
        end
      end
      rss_pkg::ST_MEAN: begin
        if (div_res.done) begin
          state_d = rss_pkg::ST_PROD;
        end
      end
      rss_pkg::ST_PROD: begin
        if (mul_res.done) begin
          state_d = rss_pkg::ST_SQSUM;
        end
      end
      rss_pkg::ST_SQSUM: begin
        if (mul_res.done) begin
          state_d = rss_pkg::ST_NSQ;
        end
      end
      rss_pkg::ST_NSQ: begin
        if (mul_res.done) begin
          state_d = rss_pkg::ST_VAR;
        end
      end
      rss_pkg::ST_VAR: begin
        if (div_res.done) begin
          state_d = rss_pkg::ST_ROOT;
        end
      end
      rss_pkg::ST_ROOT: begin
        if (rt_cnt_q == RtCntW'(1)) begin
          state_d = rss_pkg::ST_EMIT;
        end
      end
      rss_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = rss_pkg::ST_IDLE;
        end
      end
      default: state_d = rss_pkg::ST_IDLE;
    endcase
  end

  // Unit launches: each finished step starts the next one in the same cycle.
  always_comb begin
    mul_req = '0;
    div_req = '0;
    unique case (state_q)
      rss_pkg::ST_IDLE: begin
        // square the sample magnitude with a short run
        mul_req.start    = take_sample && !cnt_full;
        mul_req.short_op = 1'b1;
        mul_req.a        = MaW'(sample_mag);
        mul_req.b        = MbW'(sample_mag);
        // mean magnitude = |sum| / count
        div_req.start    = take_report && !cnt_zero;
        div_req.num      = DiffW'(sum_mag);
        div_req.den      = DenW'(cnt_q);
      end
      rss_pkg::ST_MEAN: begin
        mul_req.start = div_res.done;
        mul_req.a     = sumsq_q;
        mul_req.b     = MbW'(cnt_q);
      end
      rss_pkg::ST_PROD: begin
        mul_req.start = mul_res.done;
        mul_req.a     = MaW'(amag_q);
        mul_req.b     = amag_q;
      end
      rss_pkg::ST_SQSUM: begin
        mul_req.start = mul_res.done;
        mul_req.a     = MaW'(cnt_q);
        mul_req.b     = MbW'(cnt_q);
      end
      rss_pkg::ST_NSQ: begin
        // variance = (count*sumsq - sum*sum) / (count*count)
        div_req.start = mul_res.done;
        div_req.num   = diff_q;
        div_req.den   = mul_res.prod[DenW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Accumulators: update on each accepted sample, drop samples once the count is full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= '0;
      max_q     <= '0;
      sum_q     <= '0;
      sumsq_q   <= '0;
      cnt_q     <= '0;
      dropped_q <= 1'b0;
    end else begin
      if (take_sample) begin
        if (cnt_full) begin
          dropped_q <= 1'b1;
        end else begin
          if (cnt_zero || (sample_s < min_q)) begin
            min_q <= sample_s;
          end
          if (cnt_zero || (sample_s > max_q)) begin
            max_q <= sample_s;
          end
          sum_q <= sum_q + SumW'(sample_s);
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if ((state_q == rss_pkg::ST_SQUARE) && mul_res.done) begin
        sumsq_q <= sumsq_q + SqW'(mul_res.prod[2*SampleBits-1:0]);
      end
    end
  end

  // Report working registers.
  always_ff @(posedge clk_i) begin
    if (take_report) begin
      amag_q <= sum_mag;
      neg_q  <= sum_q[SumW-1];
    end
    if ((state_q == rss_pkg::ST_MEAN) && div_res.done) begin
      // restore the sign after the magnitude divide: truncates toward zero
      mean_q <= neg_q ? (~quot_lo) + 1'b1 : quot_lo;
    end
    if ((state_q == rss_pkg::ST_PROD) && mul_res.done) begin
      diff_q <= mul_res.prod[DiffW-1:0];
    end
    if ((state_q == rss_pkg::ST_SQSUM) && mul_res.done) begin
      diff_q <= diff_q - mul_res.prod[DiffW-1:0];
    end
    if ((state_q == rss_pkg::ST_VAR) && div_res.done) begin
      rt_val_q  <= div_res.quot;
      rt_rem_q  <= '0;
      rt_root_q <= '0;
    end else if (state_q == rss_pkg::ST_ROOT) begin
      rt_val_q  <= {rt_val_q[RootInW-3:0], 2'b00};
      rt_rem_q  <= rt_fits ? rt_sub[RemW-1:0] : rt_shift[RemW-1:0];
      rt_root_q <= {rt_root_q[RootW-2:0], rt_fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_cnt_q <= '0;
    end else if ((state_q == rss_pkg::ST_VAR) && div_res.done) begin
      rt_cnt_q <= RtCntW'(RootSteps);
    end else if (state_q == rss_pkg::ST_ROOT) begin
      rt_cnt_q <= rt_cnt_q - 1'b1;
    end
  end

  // Output register: load when free, drop valid once the transaction is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == rss_pkg::ST_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == rss_pkg::ST_EMIT) && out_free) begin
      out_q.sample_total <= cnt_q;
      out_q.saturated    <= dropped_q;
      out_q.empty_res    <= cnt_zero;
      if (cnt_zero) begin
        out_q.min_value  <= '0;
        out_q.max_value  <= '0;
        out_q.mean_value <= '0;
        out_q.std_dev    <= '0;
      end else begin
        out_q.min_value  <= min_q;
        out_q.max_value  <= max_q;
        out_q.mean_value <= mean_q;
        out_q.std_dev    <= rt_root_q[SampleBits-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A multiplier result only ever lands while a product is awaited.
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_res.done |-> (state_q == rss_pkg::ST_SQUARE || state_q == rss_pkg::ST_PROD ||
                      state_q == rss_pkg::ST_SQSUM || state_q == rss_pkg::ST_NSQ))
    else $error("multiplier finished outside a product state");

  // A divider result only ever lands while the mean or the variance is awaited.
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == rss_pkg::ST_MEAN || state_q == rss_pkg::ST_VAR))
    else $error("divider finished outside a quotient state");

  // A sample at full count is dropped: count holds and the flag sets.
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_sample && cnt_full) |=> (dropped_q && (cnt_q == $past(cnt_q))))
    else $error("sample at full count was not dropped");

  // The empty flag of a result agrees with its count.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.empty_res == (out_item_o.sample_total == '0)))
    else $error("empty flag disagrees with sample count");

endmodule
